// ----- src/pafm_pkg.sv -----
`timescale 1ns / 1ps

package pafm_pkg;

	localparam int MAX_EVENTS = 128;
	localparam int STAMP_W    = 16;
	localparam int CNT_W      = 8;
	localparam int SUM_W      = 24;
	localparam int FREQ_W     = 32;
	localparam int DIV_W      = 32;
	localparam int DIV_CNT_W  = $clog2(DIV_W);
	localparam int ADDR_W     = 4;
	localparam int DATA_W     = 32;
	localparam int MIN_STAMPS = 3;
	localparam int PRE_STAMPS = 2;

	localparam logic [31:0]        TICK_RATE_RST  = 32'd1440000;
	localparam logic [STAMP_W-1:0] MIN_PERIOD_RST = 16'd80;
	localparam logic               FAST_MODE_RST  = 1'b0;

	localparam logic [1:0] REG_TICK_RATE  = 2'd0;
	localparam logic [1:0] REG_MIN_PERIOD = 2'd1;
	localparam logic [1:0] REG_FAST_MODE  = 2'd2;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_FEW  = 2'd1;
	localparam logic [1:0] STATUS_FAST = 2'd2;

	typedef struct packed {
		logic [31:0]        tick_rate;
		logic [STAMP_W-1:0] min_period;
		logic               fast_mode;
	} cfg_t;

	typedef enum logic [1:0] {
		SEL_FEW,
		SEL_FAST,
		SEL_SAT,
		SEL_QUOT
	} out_sel_t;

	typedef struct packed {
		logic     acc_stamp;
		logic     clear_win;
		logic     start_mean;
		logic     start_freq;
		logic     load_out;
		out_sel_t out_sel;
	} cmd_t;

	typedef struct packed {
		logic few;
		logic too_fast;
		logic div_done;
		logic quot_zero;
		logic out_full;
	} sts_t;

endpackage

// ----- src/pafm_regs.sv -----
`timescale 1ns / 1ps

module pafm_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pafm_pkg::ADDR_W-1:0]  paddr,
	input  logic [pafm_pkg::DATA_W-1:0]  pwdata,
	output logic [pafm_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output pafm_pkg::cfg_t               cfg
);
	import pafm_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_rate  <= TICK_RATE_RST;
			cfg_q.min_period <= MIN_PERIOD_RST;
			cfg_q.fast_mode  <= FAST_MODE_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_TICK_RATE:  cfg_q.tick_rate  <= pwdata;
				REG_MIN_PERIOD: cfg_q.min_period <= pwdata[STAMP_W-1:0];
				REG_FAST_MODE:  cfg_q.fast_mode  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_TICK_RATE:  prdata = cfg_q.tick_rate;
			REG_MIN_PERIOD: prdata = DATA_W'(cfg_q.min_period);
			REG_FAST_MODE:  prdata = DATA_W'(cfg_q.fast_mode);
			default:        prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ----- src/pafm_div.sv -----
`timescale 1ns / 1ps

module pafm_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pafm_pkg::DIV_W-1:0]  dividend,
	input  logic [pafm_pkg::DIV_W-1:0]  divisor,
	output logic                        done,
	output logic [pafm_pkg::DIV_W-1:0]  quotient
);
	import pafm_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     quot_q;
	logic [DIV_W-1:0]     divisor_q;
	logic [DIV_W:0]       shifted;
	logic [DIV_W:0]       trial;

	assign shifted = {rem_q, quot_q[DIV_W-1]};
	assign trial   = shifted - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			quot_q    <= dividend;
			divisor_q <= divisor;
		end else if (busy_q) begin
			if (!trial[DIV_W]) begin
				rem_q <= trial[DIV_W-1:0];
			end else begin
				rem_q <= shifted[DIV_W-1:0];
			end
			quot_q <= {quot_q[DIV_W-2:0], ~trial[DIV_W]};
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

// ----- src/pafm_dp.sv -----
`timescale 1ns / 1ps

module pafm_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pafm_pkg::cfg_t                cfg,
	input  pafm_pkg::cmd_t                cmd,
	output pafm_pkg::sts_t                sts,
	input  logic [pafm_pkg::STAMP_W-1:0]  timestamp,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [pafm_pkg::FREQ_W-1:0]   frequency,
	output logic [1:0]                    status,
	output logic [pafm_pkg::CNT_W-1:0]    edge_count
);
	import pafm_pkg::*;

	logic [STAMP_W-1:0] prev_q;
	logic [CNT_W-1:0]   count_q;
	logic [SUM_W-1:0]   sum_q;
	logic               too_fast_q;
	logic [CNT_W-1:0]   hold_count_q;
	logic               out_valid_q;
	logic [FREQ_W-1:0]  frequency_q;
	logic [1:0]         status_q;
	logic [CNT_W-1:0]   edge_count_q;

	logic [STAMP_W-1:0] period;
	logic [FREQ_W-1:0]  err_val;
	logic               div_start;
	logic [DIV_W-1:0]   div_dividend;
	logic [DIV_W-1:0]   div_divisor;
	logic               div_done;
	logic [DIV_W-1:0]   div_quot;

	assign period  = timestamp - prev_q;
	assign err_val = cfg.fast_mode ? '1 : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q     <= '0;
			count_q    <= '0;
			sum_q      <= '0;
			too_fast_q <= 1'b0;
		end else if (cmd.clear_win) begin
			prev_q     <= '0;
			count_q    <= '0;
			sum_q      <= '0;
			too_fast_q <= 1'b0;
		end else if (cmd.acc_stamp && count_q < CNT_W'(MAX_EVENTS)) begin
			if (count_q >= CNT_W'(PRE_STAMPS)) begin
				if (period < cfg.min_period) begin
					too_fast_q <= 1'b1;
				end
				sum_q <= sum_q + SUM_W'(period);
			end
			prev_q  <= timestamp;
			count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_win) begin
			hold_count_q <= count_q;
		end
	end

	assign div_start    = cmd.start_mean | cmd.start_freq;
	assign div_dividend = cmd.start_mean ? DIV_W'(sum_q) : cfg.tick_rate;
	assign div_divisor  = cmd.start_mean ? DIV_W'(count_q - CNT_W'(PRE_STAMPS)) : div_quot;

	pafm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			unique case (cmd.out_sel)
				SEL_FEW: begin
					frequency_q  <= err_val;
					status_q     <= STATUS_FEW;
					edge_count_q <= count_q;
				end
				SEL_FAST: begin
					frequency_q  <= err_val;
					status_q     <= STATUS_FAST;
					edge_count_q <= count_q;
				end
				SEL_SAT: begin
					frequency_q  <= '1;
					status_q     <= STATUS_OK;
					edge_count_q <= hold_count_q;
				end
				SEL_QUOT: begin
					frequency_q  <= div_quot;
					status_q     <= STATUS_OK;
					edge_count_q <= hold_count_q;
				end
				default: ;
			endcase
		end
	end

	assign sts.few       = count_q < CNT_W'(MIN_STAMPS);
	assign sts.too_fast  = too_fast_q;
	assign sts.div_done  = div_done;
	assign sts.quot_zero = div_quot == '0;
	assign sts.out_full  = out_valid_q;

	assign result_valid = out_valid_q;
	assign frequency    = frequency_q;
	assign status       = status_q;
	assign edge_count   = edge_count_q;

endmodule

// ----- src/pafm_ctrl.sv -----
`timescale 1ns / 1ps

module pafm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  logic           req_type,
	input  pafm_pkg::sts_t sts,
	output pafm_pkg::cmd_t cmd
);
	import pafm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_MEAN = 3'b010,
		ST_FREQ = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign item_stall = (state_q != ST_IDLE) || (req_type && sts.out_full);
	assign accept     = item_valid && !item_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !req_type) begin
					cmd.acc_stamp = 1'b1;
				end else if (accept) begin
					cmd.clear_win = 1'b1;
					priority if (sts.few) begin
						cmd.load_out = 1'b1;
						cmd.out_sel  = SEL_FEW;
					end else if (sts.too_fast) begin
						cmd.load_out = 1'b1;
						cmd.out_sel  = SEL_FAST;
					end else begin
						cmd.start_mean = 1'b1;
						state_d        = ST_MEAN;
					end
				end
			end
			ST_MEAN: begin
				if (sts.div_done) begin
					if (sts.quot_zero) begin
						cmd.load_out = 1'b1;
						cmd.out_sel  = SEL_SAT;
						state_d      = ST_IDLE;
					end else begin
						cmd.start_freq = 1'b1;
						state_d        = ST_FREQ;
					end
				end
			end
			ST_FREQ: begin
				if (sts.div_done) begin
					cmd.load_out = 1'b1;
					cmd.out_sel  = SEL_QUOT;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- src/period_average_frequency_meter.sv -----
`timescale 1ns / 1ps

// Reciprocal frequency meter. Feed capture timestamps (req_type 0), then one
// window-end beat (req_type 1), which returns one result and clears the window.
// A timestamp beat may follow in every cycle while no window end is being
// divided, also while a result waits to be taken. A window end that hits an
// error (fewer than three timestamps, or a period below min_period) gives its
// result in the cycle after it is taken; a mean period that floors to zero
// gives all ones; otherwise one shared radix-2 divider runs twice (mean period,
// then tick_rate over the mean). No beat is taken while the divider runs.
// A window-end beat is stalled while a previous result is still held.
module period_average_frequency_meter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic                          req_type,
	input  logic [pafm_pkg::STAMP_W-1:0]  timestamp,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [pafm_pkg::FREQ_W-1:0]   frequency,
	output logic [1:0]                    status,
	output logic [pafm_pkg::CNT_W-1:0]    edge_count,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pafm_pkg::ADDR_W-1:0]   paddr,
	input  logic [pafm_pkg::DATA_W-1:0]   pwdata,
	output logic [pafm_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import pafm_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	pafm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pafm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.req_type   (req_type),
		.sts        (sts),
		.cmd        (cmd)
	);

	pafm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.sts          (sts),
		.timestamp    (timestamp),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.frequency    (frequency),
		.status       (status),
		.edge_count   (edge_count)
	);

	a_end_needs_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && req_type) |-> !result_valid)
		else $error("window end taken while a result is held");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (status == STATUS_OK || status == STATUS_FEW
			|| status == STATUS_FAST))
		else $error("undefined status code");

	a_error_value: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status != STATUS_OK) |-> (frequency == '0 || frequency == '1))
		else $error("error result carries a measured frequency");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> edge_count <= CNT_W'(MAX_EVENTS))
		else $error("edge count beyond window size");

	a_few_status: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && edge_count < CNT_W'(MIN_STAMPS)) |-> status == STATUS_FEW)
		else $error("short window not flagged");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import pafm_pkg::*;

	localparam logic REQ_STAMP     = 1'b0;
	localparam logic REQ_END       = 1'b1;
	localparam int   SETTLE_CYCLES = 80;
	localparam int   IDLE_LIMIT    = 4000;
	localparam int   RANDOM_BEATS  = 650;
	localparam int   NUM_PHASES    = 6;

	typedef struct packed {
		logic [FREQ_W-1:0] frequency;
		logic [1:0]        status;
		logic [CNT_W-1:0]  edge_count;
	} reading_t;

	typedef enum logic [1:0] {ROW_STAMP, ROW_END, ROW_CFG} row_kind_t;
	typedef enum logic [1:0] {SHAPE_CLEAN, SHAPE_FAST, SHAPE_NOISE} shape_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [1:0]  reg_idx;
		logic [31:0] data;
		logic        typed;
		reading_t    reading;
	} row_t;

	logic                clk;
	logic                arst_n       = 1'b0;
	logic                item_valid   = 1'b0;
	logic                item_stall;
	logic                req_type     = REQ_STAMP;
	logic [STAMP_W-1:0]  timestamp    = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	logic [FREQ_W-1:0]   frequency;
	logic [1:0]          status;
	logic [CNT_W-1:0]    edge_count;
	logic                psel         = 1'b0;
	logic                penable      = 1'b0;
	logic                pwrite       = 1'b0;
	logic [ADDR_W-1:0]   paddr        = '0;
	logic [DATA_W-1:0]   pwdata       = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	logic [31:0]         cfg_tick = TICK_RATE_RST;
	logic [STAMP_W-1:0]  cfg_min  = MIN_PERIOD_RST;
	logic                cfg_fast = FAST_MODE_RST;
	logic [STAMP_W-1:0]  win_prev = '0;
	logic [CNT_W-1:0]    win_count = '0;
	logic [SUM_W-1:0]    win_sum  = '0;
	logic                win_fast = 1'b0;

	reading_t readings_due[$];
	row_t     plan[$];

	int errors       = 0;
	int beats_sent   = 0;
	int results_seen = 0;
	int full_windows = 0;
	int writes_done  = 0;
	int quiet_cycles = 0;
	int burst_left   = 0;
	int stall_run    = 0;
	int stall_pct    = 0;
	int status_seen[4] = '{0, 0, 0, 0};

	period_average_frequency_meter dut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic bit meter_step(input logic rt, input logic [STAMP_W-1:0] ts,
		output reading_t r);
		logic [STAMP_W-1:0] per;
		logic [SUM_W-1:0]   mean;
		logic [31:0]        err_val;
		r = '0;
		if (rt == REQ_STAMP) begin
			if (win_count < MAX_EVENTS) begin
				if (win_count >= PRE_STAMPS) begin
					per = ts - win_prev;
					if (per < cfg_min)
						win_fast = 1'b1;
					win_sum = win_sum + SUM_W'(per);
				end
				win_prev  = ts;
				win_count = win_count + 1'b1;
			end
			return 1'b0;
		end
		err_val      = cfg_fast ? '1 : '0;
		r.edge_count = win_count;
		if (win_count < MIN_STAMPS) begin
			r.frequency = err_val;
			r.status    = STATUS_FEW;
		end else if (win_fast) begin
			r.frequency = err_val;
			r.status    = STATUS_FAST;
		end else begin
			mean        = win_sum / SUM_W'(win_count - PRE_STAMPS);
			r.frequency = (mean == '0) ? '1 : cfg_tick / 32'(mean);
			r.status    = STATUS_OK;
		end
		win_prev  = '0;
		win_count = '0;
		win_sum   = '0;
		win_fast  = 1'b0;
		return 1'b1;
	endfunction

	function automatic row_t stamp_row(input logic [STAMP_W-1:0] ts);
		row_t r;
		r      = '0;
		r.kind = ROW_STAMP;
		r.data = 32'(ts);
		return r;
	endfunction

	function automatic row_t end_row();
		row_t r;
		r      = '0;
		r.kind = ROW_END;
		r.data = $urandom;
		return r;
	endfunction

	function automatic row_t end_row_is(input logic [31:0] f, input logic [1:0] st,
		input logic [CNT_W-1:0] cnt);
		row_t r;
		r                    = end_row();
		r.typed              = 1'b1;
		r.reading.frequency  = f;
		r.reading.status     = st;
		r.reading.edge_count = cnt;
		return r;
	endfunction

	function automatic row_t cfg_row(input logic [1:0] idx, input logic [31:0] value);
		row_t r;
		r         = '0;
		r.kind    = ROW_CFG;
		r.reg_idx = idx;
		r.data    = value;
		return r;
	endfunction

	function automatic void check_field(input string what, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
		end
	endfunction

	task automatic send_beat(input logic rt, input logic [STAMP_W-1:0] ts, input logic typed,
		input reading_t fixed);
		reading_t pred;
		int       gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
			repeat (gap) begin
				@(negedge clk);
				item_valid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		item_valid <= 1'b1;
		req_type   <= rt;
		timestamp  <= ts;
		do @(posedge clk); while (item_stall);
		beats_sent++;
		if (meter_step(rt, ts, pred))
			readings_due.push_back(typed ? fixed : pred);
	endtask

	task automatic settle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (readings_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
		logic [31:0] kept;
		kept = value;
		case (idx)
			REG_TICK_RATE: begin
				cfg_tick = value;
			end
			REG_MIN_PERIOD: begin
				kept    = {16'd0, value[15:0]};
				cfg_min = value[15:0];
			end
			REG_FAST_MODE: begin
				kept     = {31'd0, value[0]};
				cfg_fast = value[0];
			end
			default: begin
				kept = '0;
			end
		endcase
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field("register readback", kept, prdata);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		writes_done++;
	endtask

	task automatic send_window();
		int          n;
		int          i;
		int          pick;
		int          span;
		int          fast_at;
		int unsigned per;
		shape_t      shape;
		logic [STAMP_W-1:0] ts;
		pick = $urandom_range(99);
		if (pick < 12)
			n = $urandom_range(0, 2);
		else if (pick < 15)
			n = $urandom_range(MAX_EVENTS - 2, MAX_EVENTS + 12);
		else
			n = $urandom_range(3, 24);
		pick = $urandom_range(99);
		shape = (pick < 70) ? SHAPE_CLEAN : (pick < 85) ? SHAPE_FAST : SHAPE_NOISE;
		if (shape == SHAPE_FAST && cfg_min == '0)
			shape = SHAPE_CLEAN;
		case ($urandom_range(3))
			0: span = 0;
			1: span = 15;
			2: span = 1000;
			default: span = 65535;
		endcase
		fast_at = $urandom_range(2, (n > 2) ? n - 1 : 2);
		ts = STAMP_W'($urandom);
		for (i = 0; i < n; i++) begin
			send_beat(REQ_STAMP, ts, 1'b0, '0);
			if (shape == SHAPE_NOISE) begin
				ts = STAMP_W'($urandom);
			end else begin
				per = 32'(cfg_min) + $urandom_range(0, span);
				if (per > 65535)
					per = 65535;
				if (shape == SHAPE_FAST && i + 1 == fast_at)
					per = $urandom_range(0, 32'(cfg_min) - 1);
				ts = ts + per[STAMP_W-1:0];
			end
		end
		send_beat(REQ_END, STAMP_W'($urandom), 1'b0, '0);
	endtask

	always @(negedge clk) begin
		if (stall_run == 0) begin
			stall_run = $urandom_range(8, 80);
			case ($urandom_range(3))
				0: stall_pct = 0;
				1: stall_pct = 30;
				2: stall_pct = 60;
				default: stall_pct = 95;
			endcase
		end
		stall_run--;
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin : check_results
		reading_t want;
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (readings_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none, actual %h %0d %0d",
					$time, frequency, status, edge_count);
			end else begin
				want = readings_due.pop_front();
				check_field("frequency", want.frequency, frequency);
				check_field("status", 32'(want.status), 32'(status));
				check_field("edge_count", 32'(want.edge_count), 32'(edge_count));
				status_seen[want.status]++;
				if (want.edge_count == MAX_EVENTS)
					full_windows++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= IDLE_LIMIT);
		$display("%0t: no progress for %0d cycles, %0d results outstanding",
			$time, IDLE_LIMIT, readings_due.size());
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int p;
		int goal;
		plan = '{
			end_row_is(32'd0, STATUS_FEW, 8'd0),
			stamp_row(16'd0), stamp_row(16'd100),
			end_row_is(32'd0, STATUS_FEW, 8'd2),
			stamp_row(16'h1234), stamp_row(16'hFFF0), stamp_row(16'h0054),
			end_row_is(32'd14400, STATUS_OK, 8'd3),
			stamp_row(16'd0), stamp_row(16'd500), stamp_row(16'd520), stamp_row(16'd600),
			end_row_is(32'd0, STATUS_FAST, 8'd4),
			cfg_row(REG_MIN_PERIOD, 32'd0), cfg_row(REG_FAST_MODE, 32'd1),
			stamp_row(16'hFFFF), stamp_row(16'hFFFF), stamp_row(16'hFFFF),
			end_row_is(32'hFFFF_FFFF, STATUS_OK, 8'd3),
			end_row_is(32'hFFFF_FFFF, STATUS_FEW, 8'd0),
			cfg_row(REG_TICK_RATE, 32'd0),
			stamp_row(16'd7), stamp_row(16'd17), stamp_row(16'd27),
			end_row_is(32'd0, STATUS_OK, 8'd3),
			cfg_row(REG_TICK_RATE, 32'hFFFF_FFFF),
			stamp_row(16'd0), stamp_row(16'd1), stamp_row(16'd4),
			end_row()
		};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				settle();
				cfg_write(plan[i].reg_idx, plan[i].data);
			end else begin
				send_beat((plan[i].kind == ROW_END) ? REQ_END : REQ_STAMP,
					plan[i].data[STAMP_W-1:0], plan[i].typed, plan[i].reading);
			end
		end

		for (p = 0; p < NUM_PHASES; p++) begin
			settle();
			case (p)
				0: begin
					cfg_write(REG_TICK_RATE, 32'hFFFF_FFFF);
					cfg_write(REG_MIN_PERIOD, 32'd0);
					cfg_write(REG_FAST_MODE, 32'd1);
				end
				1: begin
					cfg_write(REG_TICK_RATE, 32'd1);
					cfg_write(REG_MIN_PERIOD, 32'hFFFF);
					cfg_write(REG_FAST_MODE, 32'd0);
				end
				3: begin
					cfg_write(REG_TICK_RATE, 32'd0);
					cfg_write(REG_MIN_PERIOD, 32'd50);
					cfg_write(REG_FAST_MODE, 32'd1);
				end
				5: begin
					cfg_write(REG_TICK_RATE, TICK_RATE_RST);
					cfg_write(REG_MIN_PERIOD, 32'(MIN_PERIOD_RST));
					cfg_write(REG_FAST_MODE, 32'(FAST_MODE_RST));
				end
				default: begin
					cfg_write(REG_TICK_RATE, $urandom);
					cfg_write(REG_MIN_PERIOD, $urandom_range(0, (p == 2) ? 400 : 2000));
					cfg_write(REG_FAST_MODE, $urandom_range(1));
				end
			endcase
			goal = beats_sent + RANDOM_BEATS / NUM_PHASES;
			while (beats_sent < goal)
				send_window();
		end

		settle();
		$display("covered %0d beats and %0d results over %0d register writes",
			beats_sent, results_seen, writes_done);
		$display("results: ok %0d, too few %0d, too fast %0d, full windows %0d",
			status_seen[STATUS_OK], status_seen[STATUS_FEW], status_seen[STATUS_FAST],
			full_windows);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
